[rtl/core/thermal_pixel_to_gray_mapper_defines.svh]
// ----------------------------------------------------------------------------
// Thermal pixel to gray mapper assertion macros
// Concurrent assertion forms for the mapper top level.
// ----------------------------------------------------------------------------
`ifndef THERMAL_PIXEL_TO_GRAY_MAPPER_DEFINES_SVH
`define THERMAL_PIXEL_TO_GRAY_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mapper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mapper check failed");

`endif

[rtl/core/tpg_pkg.sv]
// ----------------------------------------------------------------------------
// Thermal pixel to gray mapper package
// Widths, constants, register map and the structs passed between stages.
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int POS_W   = 13;
    localparam int SAMP_W  = 16;
    localparam int CENTI_W = 17;
    localparam int TEMP_W  = 18;
    localparam int GRAY_W  = 8;
    localparam int QUO_W   = GRAY_W;
    localparam int REM_W   = CENTI_W + GRAY_W;
    localparam int DIV_STAGES = QUO_W / 2;

    localparam int KELVIN_OFFSET_CENTI = 27315;
    localparam int NONRAD_BIAS         = 8192;

    localparam int MODE_MEASURE = 0;
    localparam int MODE_RADIO   = 1;
    localparam int MODE_MIRROR  = 2;
    localparam int MODE_FLIP    = 3;

    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(160);
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(120);
    localparam logic [CENTI_W-1:0] MIN_RESET    = CENTI_W'(-1000);
    localparam logic [CENTI_W-1:0] MAX_RESET    = CENTI_W'(4000);

    typedef enum logic [2:0] {
        REG_WINDOW_LEFT,
        REG_WINDOW_TOP,
        REG_WINDOW_WIDTH,
        REG_WINDOW_HEIGHT,
        REG_RANGE_MIN,
        REG_RANGE_MAX,
        REG_PLANE_KELVIN,
        REG_MODE_BITS
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] window_left;
        logic [COORD_W-1:0] window_top;
        logic [SIZE_W-1:0]  window_width;
        logic [SIZE_W-1:0]  window_height;
        logic [CENTI_W-1:0] range_min;
        logic [CENTI_W-1:0] range_max;
        logic [SAMP_W-1:0]  plane_kelvin;
        logic [3:0]         mode;
        logic [CENTI_W-1:0] span;
    } cfg_t;

    typedef struct packed {
        logic               in_window;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [GRAY_W-1:0]  fixed_gray;
        logic               use_div;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [REM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
    } div_t;

endpackage

[rtl/core/tpg_regs.sv]
// ----------------------------------------------------------------------------
// Mapper configuration registers
// APB-style register file holding window, range and mode settings.
// ----------------------------------------------------------------------------
module tpg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpg_pkg::ADDR_W-1:0] paddr,
    input  logic [tpg_pkg::DATA_W-1:0] pwdata,
    output logic [tpg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tpg_pkg::cfg_t              cfg
);
    import tpg_pkg::*;

    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] top_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [CENTI_W-1:0] min_reg;
    logic [CENTI_W-1:0] max_reg;
    logic [SAMP_W-1:0]  plane_reg;
    logic [3:0]         mode_reg;
    logic [CENTI_W-1:0] span_reg;
    logic [TEMP_W-1:0]  span_next;
    reg_idx_t           idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            plane_reg  <= '0;
            mode_reg   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_WINDOW_LEFT:   left_reg   <= pwdata[COORD_W-1:0];
                REG_WINDOW_TOP:    top_reg    <= pwdata[COORD_W-1:0];
                REG_WINDOW_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_WINDOW_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                REG_RANGE_MIN:     min_reg    <= pwdata[CENTI_W-1:0];
                REG_RANGE_MAX:     max_reg    <= pwdata[CENTI_W-1:0];
                REG_PLANE_KELVIN:  plane_reg  <= pwdata[SAMP_W-1:0];
                REG_MODE_BITS:     mode_reg   <= pwdata[3:0];
            endcase
        end
    end

    // Divisor for the scaling step; only meaningful while max > min.
    assign span_next = {max_reg[CENTI_W-1], max_reg} - {min_reg[CENTI_W-1], min_reg};

    always_ff @(posedge aclk) begin
        span_reg <= span_next[CENTI_W-1:0];
    end

    always_comb begin
        unique case (idx)
            REG_WINDOW_LEFT:   prdata = DATA_W'(left_reg);
            REG_WINDOW_TOP:    prdata = DATA_W'(top_reg);
            REG_WINDOW_WIDTH:  prdata = DATA_W'(width_reg);
            REG_WINDOW_HEIGHT: prdata = DATA_W'(height_reg);
            REG_RANGE_MIN:     prdata = DATA_W'($signed(min_reg));
            REG_RANGE_MAX:     prdata = DATA_W'($signed(max_reg));
            REG_PLANE_KELVIN:  prdata = DATA_W'(plane_reg);
            REG_MODE_BITS:     prdata = DATA_W'(mode_reg);
        endcase
    end

    assign cfg = '{window_left:   left_reg,
                   window_top:    top_reg,
                   window_width:  width_reg,
                   window_height: height_reg,
                   range_min:     min_reg,
                   range_max:     max_reg,
                   plane_kelvin:  plane_reg,
                   mode:          mode_reg,
                   span:          span_reg};

endmodule

[rtl/core/tpg_front.sv]
// ----------------------------------------------------------------------------
// Mapper front stages
// Window test, temperature, clamp and scale-by-255 in three register stages.
// ----------------------------------------------------------------------------
module tpg_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tpg_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tpg_pkg::POS_W-1:0]   pos_x,
    input  logic [tpg_pkg::POS_W-1:0]   pos_y,
    input  logic [tpg_pkg::SAMP_W-1:0]  raw_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tpg_pkg::div_t               out_data
);
    import tpg_pkg::*;

    localparam logic [TEMP_W-1:0] OFS_RAD    = TEMP_W'(KELVIN_OFFSET_CENTI);
    localparam logic [TEMP_W-1:0] OFS_NONRAD = TEMP_W'(KELVIN_OFFSET_CENTI + NONRAD_BIAS);

    // stage valids and their ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    // stage 1: window result and raw temperature
    side_t              side1_reg;
    logic [TEMP_W-1:0]  temp1_reg;
    // stage 2: clamped offset above range minimum
    side_t              side2_reg;
    logic [CENTI_W-1:0] diff2_reg;
    // stage 3: numerator for the divider
    side_t              side3_reg;
    logic [REM_W-1:0]   num3_reg;

    logic [POS_W:0]     dx, dy;
    logic               in_win;
    logic [COORD_W-1:0] dest_x, dest_y;
    logic               nonrad;
    logic [TEMP_W-1:0]  temp;
    side_t              side1_next;
    logic [TEMP_W-1:0]  lo_ext, hi_ext, clamped, diff;
    logic               empty;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        dx = {pos_x[POS_W-1], pos_x} - {2'b00, cfg.window_left};
        dy = {pos_y[POS_W-1], pos_y} - {2'b00, cfg.window_top};
        in_win = !dx[POS_W] && (dx[SIZE_W-1:0] < cfg.window_width) &&
                 !dy[POS_W] && (dy[SIZE_W-1:0] < cfg.window_height);
        dest_x = cfg.mode[MODE_MIRROR] ?
                 cfg.window_width[COORD_W-1:0] - dx[COORD_W-1:0] - COORD_W'(1) :
                 dx[COORD_W-1:0];
        dest_y = cfg.mode[MODE_FLIP] ?
                 cfg.window_height[COORD_W-1:0] - dy[COORD_W-1:0] - COORD_W'(1) :
                 dy[COORD_W-1:0];

        nonrad = !cfg.mode[MODE_RADIO];
        temp   = {2'b00, raw_sample} +
                 (nonrad ? {2'b00, cfg.plane_kelvin} : TEMP_W'(0)) -
                 (nonrad ? OFS_NONRAD : OFS_RAD);

        lo_ext = {cfg.range_min[CENTI_W-1], cfg.range_min};
        hi_ext = {cfg.range_max[CENTI_W-1], cfg.range_max};
        empty  = $signed(hi_ext) <= $signed(lo_ext);

        side1_next.in_window  = in_win;
        side1_next.dest_x     = in_win ? dest_x : '0;
        side1_next.dest_y     = in_win ? dest_y : '0;
        side1_next.fixed_gray = (in_win && !cfg.mode[MODE_MEASURE]) ?
                                raw_sample[GRAY_W-1:0] : '0;
        side1_next.use_div    = in_win && cfg.mode[MODE_MEASURE] && !empty;

        // clamp into [min, max] and measure from min
        priority if ($signed(temp1_reg) < $signed(lo_ext)) begin
            clamped = lo_ext;
        end else if ($signed(temp1_reg) > $signed(hi_ext)) begin
            clamped = hi_ext;
        end else begin
            clamped = temp1_reg;
        end
        diff = clamped - lo_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            side1_reg <= side1_next;
            temp1_reg <= temp;
        end
        if (r2 && v1_reg) begin
            side2_reg <= side1_reg;
            diff2_reg <= diff[CENTI_W-1:0];
        end
        if (r3 && v2_reg) begin
            side3_reg <= side2_reg;
            // times 255 as shift and subtract
            num3_reg  <= {diff2_reg, {GRAY_W{1'b0}}} - REM_W'(diff2_reg);
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = '{side: side3_reg, rem: num3_reg, quo: '0};

endmodule

[rtl/core/tpg_div_stage.sv]
// ----------------------------------------------------------------------------
// Mapper divider stage
// Two restoring-division quotient bits per register stage.
// ----------------------------------------------------------------------------
module tpg_div_stage #(
    parameter int BIT_HI = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [tpg_pkg::CENTI_W-1:0]  divisor,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tpg_pkg::div_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tpg_pkg::div_t                out_data
);
    import tpg_pkg::*;

    localparam int BIT_LO = BIT_HI - 1;

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W-1:0] d_ext, d_hi, d_lo, rem_mid;
    logic             b_hi, b_lo;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        d_ext   = REM_W'(divisor);
        d_hi    = d_ext << BIT_HI;
        d_lo    = d_ext << BIT_LO;
        b_hi    = in_data.rem >= d_hi;
        rem_mid = b_hi ? in_data.rem - d_hi : in_data.rem;
        b_lo    = rem_mid >= d_lo;
        data_next.side = in_data.side;
        data_next.rem  = b_lo ? rem_mid - d_lo : rem_mid;
        data_next.quo  = {in_data.quo[QUO_W-3:0], b_hi, b_lo};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/thermal_pixel_to_gray_mapper.sv]
// ----------------------------------------------------------------------------
// Thermal pixel to gray mapper
// Crops, mirrors and flips pixel coordinates and maps thermal samples to gray.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock while no stage is stalled and
// returns one result transaction per pixel, in order. The pipeline has
// three front stages (window test and temperature, clamp, scale by 255)
// and four divider stages that each resolve two quotient bits of the
// scaling divide; every stage holds its own transaction, so a stalled
// output keeps accepting input until all seven stages are full. Configure
// only while no transaction is in flight; the range span is registered
// from the range registers and updates in the cycle after they change.
`include "thermal_pixel_to_gray_mapper_defines.svh"

module thermal_pixel_to_gray_mapper (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pixel input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tpg_pkg::POS_W-1:0]   s_pos_x,
    input  logic [tpg_pkg::POS_W-1:0]   s_pos_y,
    input  logic [tpg_pkg::SAMP_W-1:0]  s_raw_sample,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_in_window,
    output logic [tpg_pkg::COORD_W-1:0] m_dest_x,
    output logic [tpg_pkg::COORD_W-1:0] m_dest_y,
    output logic [tpg_pkg::GRAY_W-1:0]  m_gray_level,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpg_pkg::DATA_W-1:0]  pwdata,
    output logic [tpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tpg_pkg::*;

    cfg_t cfg;

    // stage chain: index 0 is the front output, the last index the result
    logic stage_valid [DIV_STAGES+1];
    logic stage_ready [DIV_STAGES+1];
    div_t stage_data  [DIV_STAGES+1];
    logic front_ready;

    tpg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_ready   (front_ready),
        .pos_x      (s_pos_x),
        .pos_y      (s_pos_y),
        .raw_sample (s_raw_sample),
        .out_valid  (stage_valid[0]),
        .out_ready  (stage_ready[0]),
        .out_data   (stage_data[0])
    );

    assign s_ready = front_ready;

    // Quotient bits resolve most significant first.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        tpg_div_stage #(
            .BIT_HI (QUO_W - 1 - 2 * g)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .divisor   (cfg.span),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // Advance the last stage when the result transaction is taken.
    assign stage_ready[DIV_STAGES] = m_ready;

    assign m_valid      = stage_valid[DIV_STAGES];
    assign m_in_window  = stage_data[DIV_STAGES].side.in_window;
    assign m_dest_x     = stage_data[DIV_STAGES].side.dest_x;
    assign m_dest_y     = stage_data[DIV_STAGES].side.dest_y;
    // Quotient when use_div (measuring, inside, non-empty range), else the fixed byte.
    assign m_gray_level = stage_data[DIV_STAGES].side.use_div ?
                          stage_data[DIV_STAGES].quo :
                          stage_data[DIV_STAGES].side.fixed_gray;

    // An outside pixel carries all-zero fields.
    `TPG_ASSERT_IMPL(a_outside_zero, aclk, aresetn, m_valid && !m_in_window, m_dest_x == '0 && m_dest_y == '0 && m_gray_level == '0)

    // A remainder not below the span would mean the quotient overflowed its eight bits.
    `TPG_ASSERT_IMPL(a_rem_below_span, aclk, aresetn, m_valid && stage_data[DIV_STAGES].side.use_div, stage_data[DIV_STAGES].rem < REM_W'(cfg.span))

    // Input is refused only when every stage already holds a transaction.
    `TPG_ASSERT_IMPL(a_ready_full, aclk, aresetn, !s_ready, stage_valid[0] && stage_valid[1] && stage_valid[2] && stage_valid[3] && stage_valid[4] && !m_ready)

    // Columns, mirrored or not, stay inside a window narrower than the coordinate space.
    `TPG_ASSERT_IMPL(a_dest_x_range, aclk, aresetn, m_valid && m_in_window && !cfg.window_width[SIZE_W-1], SIZE_W'(m_dest_x) < cfg.window_width)

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Thermal pixel to gray mapper testbench
// Drives pixel transactions with random gaps and result back-pressure,
// predicts every result, and compares results field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tpg_pkg::*;

    // Scaling constants for the gray predictor and the stimulus, plus run limits.
    localparam int     CELSIUS_ZERO_CENTI = 27315;
    localparam int     UNCAL_SAMPLE_BIAS  = 8192;
    localparam longint GRAY_SPAN          = 255;
    localparam int     STALL_LIMIT        = 2000;
    localparam int     LONG_HOLD_CYCLES   = 300;
    localparam int     RANDOM_PHASES      = 12;
    localparam int     PIXELS_PER_PHASE   = 153;

    typedef struct {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SAMP_W-1:0] raw_sample;
    } pixel_t;

    typedef struct {
        logic               in_window;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [GRAY_W-1:0]  gray_level;
    } mapped_pixel_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [POS_W-1:0]    s_pos_x      = '0;
    logic [POS_W-1:0]    s_pos_y      = '0;
    logic [SAMP_W-1:0]   s_raw_sample = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic                m_in_window;
    logic [COORD_W-1:0]  m_dest_x;
    logic [COORD_W-1:0]  m_dest_y;
    logic [GRAY_W-1:0]   m_gray_level;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the register file, starting at the reset values.
    logic [COORD_W-1:0]        win_left   = '0;
    logic [COORD_W-1:0]        win_top    = '0;
    logic [SIZE_W-1:0]         win_width  = SIZE_W'(160);
    logic [SIZE_W-1:0]         win_height = SIZE_W'(120);
    logic signed [CENTI_W-1:0] clamp_lo   = -17'sd1000;
    logic signed [CENTI_W-1:0] clamp_hi   = 17'sd4000;
    logic [SAMP_W-1:0]         fpa_centi  = '0;
    logic [3:0]                mode_sel   = '0;

    pixel_t        pending_pixels[$];
    mapped_pixel_t expected_pixels[$];

    int send_gap_pct      = 0;
    int recv_stall_pct    = 0;
    int recv_hold_cycles  = 0;
    int mismatches        = 0;
    int quiet_cycles      = 0;

    thermal_pixel_to_gray_mapper dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_raw_sample (s_raw_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_in_window  (m_in_window),
        .m_dest_x     (m_dest_x),
        .m_dest_y     (m_dest_y),
        .m_gray_level (m_gray_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 aclk = ~aclk;

    // Crop, mirror/flip and gray mapping of one pixel under the shadow registers.
    function automatic mapped_pixel_t map_pixel(input pixel_t px);
        mapped_pixel_t res;
        int            col;
        int            row;
        longint        temp;
        longint        lo;
        longint        hi;
        res = '{in_window: 1'b0, dest_x: '0, dest_y: '0, gray_level: '0};
        col = int'($signed(px.pos_x)) - int'(win_left);
        row = int'($signed(px.pos_y)) - int'(win_top);
        // Anything outside the crop window comes back as all zeros.
        if (col < 0 || col >= int'(win_width) || row < 0 || row >= int'(win_height))
            return res;
        if (mode_sel[MODE_MIRROR])
            col = int'(win_width) - col - 1;
        if (mode_sel[MODE_FLIP])
            row = int'(win_height) - row - 1;
        res.in_window = 1'b1;
        res.dest_x    = col[COORD_W-1:0];
        res.dest_y    = row[COORD_W-1:0];
        if (!mode_sel[MODE_MEASURE]) begin
            res.gray_level = px.raw_sample[GRAY_W-1:0];
        end else begin
            lo   = clamp_lo;
            hi   = clamp_hi;
            temp = longint'(px.raw_sample);
            if (!mode_sel[MODE_RADIO])
                temp = temp - UNCAL_SAMPLE_BIAS + longint'(fpa_centi);
            if (hi > lo) begin
                temp = temp - CELSIUS_ZERO_CENTI;
                if (temp < lo)
                    temp = lo;
                else if (temp > hi)
                    temp = hi;
                res.gray_level = GRAY_W'(((temp - lo) * GRAY_SPAN) / (hi - lo));
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: predict on every accepted transaction, then hold the
    // current pixel or advance to the next one from the pending queue.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(map_pixel('{s_pos_x, s_pos_y, s_raw_sample}));
            if (!s_valid || s_ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = pending_pixels.pop_front();
                    s_valid      <= 1'b1;
                    s_pos_x      <= nxt.pos_x;
                    s_pos_y      <= nxt.pos_y;
                    s_raw_sample <= nxt.raw_sample;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // prediction, and drive ready with random stalls or a long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        mapped_pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transaction with no pixel outstanding");
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_in_window !== want.in_window) begin
                        $error("in_window: expected %0d, got %0d", want.in_window, m_in_window);
                        mismatches++;
                    end
                    if (m_dest_x !== want.dest_x) begin
                        $error("dest_x: expected %0d, got %0d", want.dest_x, m_dest_x);
                        mismatches++;
                    end
                    if (m_dest_y !== want.dest_y) begin
                        $error("dest_y: expected %0d, got %0d", want.dest_y, m_dest_y);
                        mismatches++;
                    end
                    if (m_gray_level !== want.gray_level) begin
                        $error("gray_level: expected %0d, got %0d",
                               want.gray_level, m_gray_level);
                        mismatches++;
                    end
                end
            end
            // Count down a requested hold-off; the pipeline fills and stalls input.
            if (recv_hold_cycles > 0) begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                m_ready          <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input reg_idx_t idx, input int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the whole register file and mirror it into the shadow copy.
    task automatic set_config(input int left, input int top, input int width,
                              input int height, input int lo, input int hi,
                              input int fpa, input int mode);
        apb_write(REG_WINDOW_LEFT,   left);
        apb_write(REG_WINDOW_TOP,    top);
        apb_write(REG_WINDOW_WIDTH,  width);
        apb_write(REG_WINDOW_HEIGHT, height);
        apb_write(REG_RANGE_MIN,     lo);
        apb_write(REG_RANGE_MAX,     hi);
        apb_write(REG_PLANE_KELVIN,  fpa);
        apb_write(REG_MODE_BITS,     mode);
        win_left   = COORD_W'(left);
        win_top    = COORD_W'(top);
        win_width  = SIZE_W'(width);
        win_height = SIZE_W'(height);
        clamp_lo   = CENTI_W'(lo);
        clamp_hi   = CENTI_W'(hi);
        fpa_centi  = SAMP_W'(fpa);
        mode_sel   = 4'(mode);
        @(negedge aclk);
    endtask

    task automatic queue_pixel(input int x, input int y, input int raw);
        pending_pixels.push_back('{POS_W'(x), POS_W'(y), SAMP_W'(raw)});
    endtask

    // Hold the sender until every queued pixel has been mapped and checked.
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed corner cases, then random phases that each pick a
    // configuration and an idling pattern.
    // ------------------------------------------------------------------------
    initial begin
        int left, top, width, height, lo, hi, fpa, mode;
        int x, y, raw, span, temp;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: pass-through gray, window edges and far corners.
        queue_pixel(0, 0, 16'h00ff);
        queue_pixel(159, 119, 16'hff00);
        queue_pixel(160, 5, 16'h1234);
        queue_pixel(5, 120, 16'h4321);
        queue_pixel(-1, 0, 16'hffff);
        queue_pixel(-2048, -2048, 16'hffff);
        queue_pixel(4095, 4095, 16'h0000);
        wait_drained();

        // Single-pixel window at the far corner, all mode bits, widest range.
        set_config(4095, 4095, 1, 1, -1000, 60000, 65535, 15);
        queue_pixel(4095, 4095, 0);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(4094, 4095, 30000);
        wait_drained();

        // Full-size window, uncalibrated samples, clamps on both sides.
        set_config(0, 0, 4096, 4096, 0, 100, 0, 1 << MODE_MEASURE | 1 << MODE_MIRROR);
        queue_pixel(0, 0, CELSIUS_ZERO_CENTI + UNCAL_SAMPLE_BIAS + 50);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(100, 200, 0);
        wait_drained();

        // Empty range: minimum above maximum gives black in measurement mode.
        set_config(0, 0, 64, 64, 60000, -1000, 1234, 1 << MODE_MEASURE | 1 << MODE_RADIO);
        queue_pixel(10, 10, 30000);
        queue_pixel(63, 0, 0);
        wait_drained();

        // Zero-width window: nothing can be inside.
        set_config(0, 0, 0, 5, -1000, 4000, 0, 0);
        queue_pixel(0, 0, 16'h00aa);
        queue_pixel(1, 1, 16'h0055);
        wait_drained();

        // Window larger than 4096: mirrored and flipped coordinates wrap.
        set_config(0, 0, 6000, 5000, -1000, 4000, 0, 1 << MODE_MIRROR | 1 << MODE_FLIP);
        queue_pixel(0, 0, 16'h0001);
        queue_pixel(4095, 4095, 16'h0080);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(2))
                0:       left = 0;
                1:       left = 4095;
                default: left = $urandom_range(4095);
            endcase
            top = ($urandom_range(2) == 0) ? 0 : int'($urandom_range(4095));
            case ($urandom_range(3))
                0:       width = 1;
                1:       width = 4096;
                2:       width = $urandom_range(64, 1);
                default: width = $urandom_range(4096, 1);
            endcase
            height = ($urandom_range(3) == 0) ? 4096 : int'($urandom_range(64, 1));
            case ($urandom_range(4))
                0: begin
                    lo = -1000;
                    hi = 60000;
                end
                1: begin
                    // empty range, equal or inverted
                    lo = int'($urandom_range(61000)) - 1000;
                    hi = lo - int'($urandom_range(500));
                    if (hi < -1000)
                        hi = -1000;
                end
                2: begin
                    lo = int'($urandom_range(60000)) - 1000;
                    hi = lo + int'($urandom_range(50, 1));
                    if (hi > 60000)
                        hi = 60000;
                end
                default: begin
                    lo = int'($urandom_range(61000)) - 1000;
                    hi = int'($urandom_range(61000)) - 1000;
                    if (lo > hi) begin
                        temp = lo;
                        lo   = hi;
                        hi   = temp;
                    end
                end
            endcase
            case ($urandom_range(2))
                0:       fpa = 0;
                1:       fpa = 65535;
                default: fpa = $urandom_range(65535);
            endcase
            mode = $urandom_range(15);
            if ($urandom_range(3) != 0)
                mode = mode | (1 << MODE_MEASURE);
            set_config(left, top, width, height, lo, hi, fpa, mode);

            // Cycle through no idling, sender gaps, receiver stalls, and both.
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
                default: begin send_gap_pct = 7; recv_stall_pct = 7; end
            endcase

            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                // Mostly aim at the window and its border, sometimes anywhere.
                if ($urandom_range(3) != 0)
                    x = left + int'($urandom_range(width + 1)) - 1;
                else
                    x = int'($urandom_range(6143)) - 2048;
                if ($urandom_range(3) != 0)
                    y = top + int'($urandom_range(height + 1)) - 1;
                else
                    y = int'($urandom_range(6143)) - 2048;
                if (x > 4095) x = 4095;
                if (y > 4095) y = 4095;
                if (x < -2048) x = -2048;
                if (y < -2048) y = -2048;
                if (mode[MODE_MEASURE] && $urandom_range(1) == 0) begin
                    // Land near the clamp range, with a margin past both ends.
                    span = (hi > lo) ? hi - lo : 100;
                    raw  = lo - 200 + int'($urandom_range(span + 400)) + CELSIUS_ZERO_CENTI;
                    if (!mode[MODE_RADIO])
                        raw = raw + UNCAL_SAMPLE_BIAS - fpa;
                    if (raw < 0) raw = 0;
                    if (raw > 65535) raw = 65535;
                end else begin
                    raw = $urandom_range(65535);
                end
                queue_pixel(x, y, raw);
            end
            // Once, stop taking results while the sender keeps offering pixels.
            if (phase == 4)
                recv_hold_cycles = LONG_HOLD_CYCLES;
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[thermal_pixel_to_gray_mapper.f]
+incdir+rtl/core
rtl/core/tpg_pkg.sv
rtl/core/tpg_regs.sv
rtl/core/tpg_front.sv
rtl/core/tpg_div_stage.sv
rtl/core/thermal_pixel_to_gray_mapper.sv
test/tb_top.sv
